[rtl/dfa_pkg.sv]
// Package for the programmable automaton recognizer.
// Holds field widths, operation codes, register indexes and the controller command type.
// Depends on nothing; every other file of the block imports it.
package dfa_pkg;

  localparam int STATE_W       = 4;
  localparam int SYMBOL_W      = 8;
  localparam int SLOT_W        = 4;
  localparam int COUNT_W       = 5;
  localparam int MASK_W        = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 16;
  // Largest number of table slots that the slot field can address.
  localparam int MAX_SLOTS     = 16;

  localparam int NUM_ENTRIES_DEF = 16;
  localparam int NUM_STATES_DEF  = 16;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_SYMBOL  = 2'd1,
    OP_END     = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  localparam logic [CFG_INDEX_W-1:0] REG_TRANSITION_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_STATE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEPT_MASK      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the incoming item
    logic commit;   // apply the held item and load the result register
  } cmd_t;

endpackage

[rtl/dfa_op_if.sv]
// Handshake interface for the operation items fed to the recognizer.
// Depends on dfa_pkg for the field widths.
interface dfa_op_if;
  import dfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  logic [SLOT_W-1:0]   entry_index;
  logic [STATE_W-1:0]  from_state;
  logic [STATE_W-1:0]  to_state;
  logic [SYMBOL_W-1:0] symbol;

  modport source (
    output valid, operation, entry_index, from_state, to_state, symbol,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_index, from_state, to_state, symbol,
    output ready
  );
endinterface

[rtl/dfa_res_if.sv]
// Handshake interface for the result items of the recognizer.
// Depends on dfa_pkg for the field widths.
interface dfa_res_if;
  import dfa_pkg::*;

  logic               valid;
  logic               ready;
  logic               moved;
  logic [STATE_W-1:0] current_state;
  logic               halted;
  logic               accepted;

  modport source (
    output valid, moved, current_state, halted, accepted,
    input  ready
  );

  modport sink (
    input  valid, moved, current_state, halted, accepted,
    output ready
  );
endinterface

[rtl/dfa_symbol_recognizer_top.sv]
// Top level of the programmable automaton recognizer.
// Joins dfa_ctrl and dfa_dp to the item interfaces; depends on dfa_pkg, dfa_op_if, dfa_res_if.

// Programmable deterministic automaton. Each item on ops writes one transition table slot,
// feeds one symbol, ends a string or restarts at initial_state, and each item gives exactly
// one item on results. A symbol takes the lowest-numbered of the first transition_count slots
// whose source equals the present state and whose symbol matches; with no match the
// automaton halts and ignores symbols until a restart or the end item, which reports
// acceptance and clears the halt. Each item is registered first; then all slots are compared
// in parallel and, once the result register is free, the state is updated and the result
// register is loaded. The controller holds one item at a time. A new item is taken while the
// previous result still waits on results; the block only stalls when a second result would
// have nowhere to go. Table slots read before they were ever written give undefined results.
// The user must write configuration registers through cfg_wen, cfg_index and cfg_data only
// while no item is in flight; the block does not enforce this. They take effect at once,
// except initial_state, which is used at the next restart item.
module dfa_symbol_recognizer_top #(
  parameter int NUM_ENTRIES = dfa_pkg::NUM_ENTRIES_DEF,
  parameter int NUM_STATES  = dfa_pkg::NUM_STATES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  dfa_op_if.sink                          ops,
  dfa_res_if.source                       results,
  input  logic                            cfg_wen,
  input  logic [dfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dfa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dfa_pkg::*;

  cmd_t ctrl_cmd;
  logic in_ready;
  logic out_valid;

  // The controller decides when an item is taken and when its result is committed.
  dfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ops.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .cmd       (ctrl_cmd)
  );

  // The datapath holds the table, the automaton state and the result payload.
  dfa_dp #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .NUM_STATES  (NUM_STATES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (ctrl_cmd),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .operation     (ops.operation),
    .entry_index   (ops.entry_index),
    .from_state    (ops.from_state),
    .to_state      (ops.to_state),
    .symbol        (ops.symbol),
    .moved         (results.moved),
    .current_state (results.current_state),
    .halted        (results.halted),
    .accepted      (results.accepted)
  );

  assign ops.ready     = in_ready;
  assign results.valid = out_valid;

  // A committed item always shows up as a pending result in the next cycle.
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl_cmd.commit |=> results.valid)
    else $error("committed item did not produce a result");

  // Only one item is in flight: the block is not ready in the cycle after it takes an item.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    ops.valid && ops.ready |=> !ops.ready)
    else $error("item accepted while another item is being worked on");

  // A successful move never leaves the automaton halted.
  a_moved_not_halted: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.moved && results.halted))
    else $error("result reports a move and a halt together");

  // An accepting item never also reports a move or a halt.
  a_accept_not_moved: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> !(results.accepted && (results.moved || results.halted)))
    else $error("accepting result carries move or halt");
endmodule

[rtl/dfa_ctrl.sv]
// Controller of the recognizer: a two-state machine that sequences one item at a time.
// Owns the handshakes and the result valid flag. Depends on dfa_pkg.
module dfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output dfa_pkg::cmd_t cmd
);
  import dfa_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   slot_free;

  // The result register can take a new result when it is empty or drains now.
  assign slot_free   = !out_valid || out_ready;
  assign in_ready    = (state == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = (state == ST_EXEC) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
          if (cmd.capture) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state     <= ST_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end
endmodule

[rtl/dfa_dp.sv]
// Datapath of the recognizer: item register, transition table, present state,
// stop flag, configuration registers, parallel match and result register. Depends on dfa_pkg.
module dfa_dp #(
  parameter int NUM_ENTRIES = dfa_pkg::NUM_ENTRIES_DEF,
  parameter int NUM_STATES  = dfa_pkg::NUM_STATES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dfa_pkg::cmd_t                    cmd,
  input  logic                             cfg_wen,
  input  logic [dfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dfa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                       operation,
  input  logic [dfa_pkg::SLOT_W-1:0]       entry_index,
  input  logic [dfa_pkg::STATE_W-1:0]      from_state,
  input  logic [dfa_pkg::STATE_W-1:0]      to_state,
  input  logic [dfa_pkg::SYMBOL_W-1:0]     symbol,
  output logic                             moved,
  output logic [dfa_pkg::STATE_W-1:0]      current_state,
  output logic                             halted,
  output logic                             accepted
);
  import dfa_pkg::*;

  // Slots past what the slot field can address are never written, so they are not built.
  localparam int DEPTH = (NUM_ENTRIES < MAX_SLOTS) ? NUM_ENTRIES : MAX_SLOTS;

  // Configuration registers.
  logic [COUNT_W-1:0] transition_count;
  logic [STATE_W-1:0] initial_state;
  logic [MASK_W-1:0]  accept_mask;

  // Held item.
  op_t                op_q;
  logic [SLOT_W-1:0]  idx_q;
  logic [STATE_W-1:0] from_q;
  logic [STATE_W-1:0] to_q;
  logic [SYMBOL_W-1:0] sym_q;

  // Transition table, one register per slot.
  logic [STATE_W-1:0]  entry_source [DEPTH];
  logic [SYMBOL_W-1:0] entry_symbol [DEPTH];
  logic [STATE_W-1:0]  entry_target [DEPTH];

  logic [STATE_W-1:0] present_state;
  logic               stop_flag;

  logic [DEPTH-1:0]   hit;
  logic               found;
  logic [STATE_W-1:0] hit_target;
  logic [STATE_W-1:0] present_state_next;
  logic               stop_flag_next;
  logic               moved_next;
  logic               accepted_next;
  logic               state_accepting;

  always_ff @(posedge clk) begin
    if (rst) begin
      transition_count <= '0;
      initial_state    <= '0;
      accept_mask      <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_TRANSITION_COUNT: transition_count <= cfg_data[COUNT_W-1:0];
        REG_INITIAL_STATE:    initial_state    <= cfg_data[STATE_W-1:0];
        REG_ACCEPT_MASK:      accept_mask      <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op_t'(operation);
      idx_q  <= entry_index;
      from_q <= from_state;
      to_q   <= to_state;
      sym_q  <= symbol;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.commit && (op_q == OP_WRITE) && (idx_q == SLOT_W'(i))) begin
        entry_source[i] <= from_q;
        entry_symbol[i] <= sym_q;
        entry_target[i] <= to_q;
      end
    end
  end

  // Every slot is compared at once; the lowest matching slot wins.
  always_comb begin
    hit        = '0;
    hit_target = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = (COUNT_W'(i) < transition_count) && (entry_source[i] == present_state) &&
               (entry_symbol[i] == sym_q);
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_target = entry_target[i];
      end
    end
  end

  assign found           = |hit;
  assign state_accepting = (int'(present_state) < NUM_STATES) && accept_mask[present_state];

  always_comb begin
    present_state_next = present_state;
    stop_flag_next     = stop_flag;
    moved_next         = 1'b0;
    accepted_next      = 1'b0;
    case (op_q)
      OP_WRITE: ;
      OP_SYMBOL: begin
        if (!stop_flag) begin
          if (found) begin
            present_state_next = hit_target;
            moved_next         = 1'b1;
          end else begin
            stop_flag_next = 1'b1;
          end
        end
      end
      OP_END: begin
        accepted_next  = !stop_flag && state_accepting;
        stop_flag_next = 1'b0;
      end
      OP_RESTART: begin
        present_state_next = initial_state;
        stop_flag_next     = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_state <= '0;
      stop_flag     <= 1'b0;
    end else if (cmd.commit) begin
      present_state <= present_state_next;
      stop_flag     <= stop_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      moved         <= moved_next;
      current_state <= present_state_next;
      halted        <= stop_flag_next;
      accepted      <= accepted_next;
    end
  end
endmodule

[tb/testbench.sv]
// Self-checking testbench for dfa_symbol_recognizer_top, the programmable automaton recognizer.
// It drives operation items and register writes and checks every result item against its own
// automaton model. Depends on dfa_pkg, dfa_op_if, dfa_res_if and the top level of the block.
`timescale 1ns / 1ps

module testbench;
  import dfa_pkg::*;

  // The table depth that the block is built with.
  localparam int NUM_SLOTS = NUM_ENTRIES_DEF;
  // Cycles without any accepted item before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Length of the long receiver hold-off that makes the block back up.
  localparam int HOLD_CYCLES = 80;
  // Stimulus stops once this many operation items have gone in.
  localparam int ITEM_TARGET = 1100;

  // One operation item as it goes onto the ops channel.
  typedef struct packed {
    op_t                 op;
    logic [SLOT_W-1:0]   slot;
    logic [STATE_W-1:0]  src;
    logic [STATE_W-1:0]  dst;
    logic [SYMBOL_W-1:0] sym;
  } op_item_t;

  // One result item as it comes off the results channel.
  typedef struct packed {
    logic               moved;
    logic [STATE_W-1:0] state;
    logic               halted;
    logic               accepted;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  dfa_op_if  ops_if ();
  dfa_res_if res_if ();

  dfa_symbol_recognizer_top uut (
    .clk       (clk),
    .rst       (rst),
    .ops       (ops_if),
    .results   (res_if),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model of the automaton: table, present state, halt flag and a copy of the registers.
  // It is advanced once for every operation item at the edge where the item is accepted.
  logic [STATE_W-1:0]  slot_src [NUM_SLOTS];
  logic [SYMBOL_W-1:0] slot_sym [NUM_SLOTS];
  logic [STATE_W-1:0]  slot_dst [NUM_SLOTS];
  logic [STATE_W-1:0]  cur_state = '0;
  logic                halt_flag = 1'b0;
  logic [COUNT_W-1:0]  reg_count = '0;
  logic [STATE_W-1:0]  reg_initial = '0;
  logic [MASK_W-1:0]   reg_mask = '0;

  verdict_t expected_verdicts [$];
  verdict_t oldest;
  int       mismatches = 0;
  int       sent_items = 0;
  int       quiet_cycles = 0;

  // Test control shared between the stimulus and the receiver. When idle_on is clear both
  // sides run without gaps; hold_results asks the receiver for one long hold-off.
  bit idle_on = 1'b1;
  bit hold_results = 1'b0;

  // Applies one item to the model and returns the result that the block must give for it.
  function automatic verdict_t step_automaton(op_item_t it);
    verdict_t v;
    int       n;
    v = '0;
    case (it.op)
      OP_WRITE: begin
        slot_src[it.slot] = it.src;
        slot_sym[it.slot] = it.sym;
        slot_dst[it.slot] = it.dst;
      end
      OP_SYMBOL: begin
        // A halted automaton skips symbols until the end of the string.
        if (!halt_flag) begin
          // Counts above the table depth search the whole table and no further.
          n = (reg_count > NUM_SLOTS) ? NUM_SLOTS : int'(reg_count);
          for (int i = 0; i < n; i++) begin
            if (!v.moved && slot_src[i] == cur_state && slot_sym[i] == it.sym) begin
              cur_state = slot_dst[i];
              v.moved   = 1'b1;
            end
          end
          if (!v.moved) halt_flag = 1'b1;
        end
      end
      OP_END: begin
        // The state is kept across the end of a string; only the halt clears.
        v.accepted = !halt_flag && reg_mask[cur_state];
        halt_flag  = 1'b0;
      end
      default: begin
        cur_state = reg_initial;
        halt_flag = 1'b0;
      end
    endcase
    v.state  = cur_state;
    v.halted = halt_flag;
    return v;
  endfunction

  // Picks a symbol that mostly follows an existing transition out of the present state,
  // so that strings walk deep into the table rather than halting at once.
  function automatic logic [SYMBOL_W-1:0] pick_symbol(logic [SYMBOL_W-1:0] base);
    logic [SYMBOL_W-1:0] hits [$];
    int                  n;
    n = (reg_count > NUM_SLOTS) ? NUM_SLOTS : int'(reg_count);
    for (int i = 0; i < n; i++) begin
      if (slot_src[i] == cur_state) hits.push_back(slot_sym[i]);
    end
    if (hits.size() > 0 && $urandom_range(0, 9) < 8) return hits[$urandom_range(0, hits.size() - 1)];
    if ($urandom_range(0, 9) == 0) return SYMBOL_W'($urandom);
    return base + SYMBOL_W'($urandom_range(0, 3));
  endfunction

  // Every field random; the callers override the ones that matter for the operation, so the
  // fields that an operation ignores still see every value.
  function automatic op_item_t random_item();
    op_item_t it;
    it.op   = op_t'($urandom_range(0, 3));
    it.slot = SLOT_W'($urandom);
    it.src  = STATE_W'($urandom);
    it.dst  = STATE_W'($urandom);
    it.sym  = SYMBOL_W'($urandom);
    return it;
  endfunction

  // Offers one item after a random gap and returns at the edge where it is accepted.
  // The expected result is queued at that same edge.
  task automatic send_op(op_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      ops_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ops_if.valid       <= 1'b1;
    ops_if.operation   <= it.op;
    ops_if.entry_index <= it.slot;
    ops_if.from_state  <= it.src;
    ops_if.to_state    <= it.dst;
    ops_if.symbol      <= it.sym;
    do @(posedge clk); while (!ops_if.ready);
    expected_verdicts.push_back(step_automaton(it));
    sent_items++;
  endtask

  task automatic do_write(int slot, int src, int dst, int sym);
    op_item_t it;
    it      = random_item();
    it.op   = OP_WRITE;
    it.slot = SLOT_W'(slot);
    it.src  = STATE_W'(src);
    it.dst  = STATE_W'(dst);
    it.sym  = SYMBOL_W'(sym);
    send_op(it);
  endtask

  task automatic do_symbol(int sym);
    op_item_t it;
    it     = random_item();
    it.op  = OP_SYMBOL;
    it.sym = SYMBOL_W'(sym);
    send_op(it);
  endtask

  task automatic do_end();
    op_item_t it;
    it    = random_item();
    it.op = OP_END;
    send_op(it);
  endtask

  task automatic do_restart();
    op_item_t it;
    it    = random_item();
    it.op = OP_RESTART;
    send_op(it);
  endtask

  // Stops offering items and waits until every expected result has come back, so that the
  // registers can be written with nothing in flight.
  task automatic wait_idle();
    ops_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write; the model takes the new value at the same edge as the block.
  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_TRANSITION_COUNT: reg_count   = COUNT_W'(value);
      REG_INITIAL_STATE:    reg_initial = STATE_W'(value);
      REG_ACCEPT_MASK:      reg_mask    = MASK_W'(value);
      default: ;
    endcase
  endtask

  task automatic set_registers(int count, int initial_st, int mask);
    wait_idle();
    cfg_write(REG_TRANSITION_COUNT, count);
    cfg_write(REG_INITIAL_STATE, initial_st);
    cfg_write(REG_ACCEPT_MASK, mask);
  endtask

  // Fills every slot once, so that no later search can read a slot that was never written.
  // Slot 3 repeats the key of slot 0 with another target to check that the lowest slot wins,
  // and slot 15 is only reachable when the count reaches past 15.
  task automatic test_table_fill();
    do_write(0, 0, 1, 8'h00);
    do_write(1, 1, 15, 8'hFF);
    do_write(2, 15, 0, 8'h80);
    do_write(3, 0, 2, 8'h00);
    for (int i = 4; i < 15; i++) do_write(i, i, 15 - i, i * 17);
    do_write(15, 0, 3, 8'h01);
  endtask

  // A string that is accepted, then one that halts on a missing transition, skips a symbol
  // while halted and is rejected at its end.
  task automatic test_first_match_and_accept();
    set_registers(16, 0, 16'h8002);
    do_restart();
    do_symbol(8'h00);
    do_symbol(8'hFF);
    do_end();
    do_symbol(8'h80);
    do_symbol(8'h42);
    do_symbol(8'h00);
    do_end();
  endtask

  // A count above the table depth, and a new initial state that only counts after a restart.
  task automatic test_large_count_and_initial();
    set_registers(31, 15, 16'hFFFF);
    do_symbol(8'h01);
    do_restart();
    do_symbol(8'h80);
    do_end();
  endtask

  // With no slot in use every symbol halts, whatever the table holds.
  task automatic test_empty_table();
    set_registers(0, 0, 16'h0000);
    do_symbol(8'h00);
    do_end();
    do_restart();
  endtask

  // The receiver holds off for a long stretch while items keep coming without gaps, so the
  // block fills up and has to stall its input.
  task automatic test_backpressure();
    set_registers(16, 0, 16'h0002);
    idle_on      = 1'b0;
    hold_results = 1'b1;
    do_restart();
    for (int i = 0; i < 14; i++) begin
      if (i % 5 == 4) do_end();
      else do_symbol(pick_symbol(8'h00));
    end
    wait_idle();
    idle_on = 1'b1;
  endtask

  // Phases of random tables over mostly four states and a small alphabet, each followed by
  // strings that mostly follow the table; a tenth of the steps send one fully random item instead.
  task automatic test_random_walks();
    int                  phase;
    int                  count;
    int                  init_st;
    int                  mask;
    int                  top_state;
    int                  phase_start;
    int                  len;
    int                  order [NUM_SLOTS];
    int                  j;
    int                  tmp;
    logic [SYMBOL_W-1:0] base;
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       count = 0;
        1:       count = 16;
        2:       count = 31;
        default: count = $urandom_range(4, 16);
      endcase
      top_state = ($urandom_range(0, 3) == 0) ? 15 : 3;
      init_st   = (phase == 0) ? 15 : $urandom_range(0, top_state);
      case (phase)
        1:       mask = 16'h0000;
        2:       mask = 16'hFFFF;
        default: mask = $urandom_range(0, 16'hFFFF);
      endcase
      set_registers(count, init_st, mask);
      idle_on = ($urandom_range(0, 3) != 0);
      base    = SYMBOL_W'($urandom);

      // Rewrite the whole table in a shuffled slot order.
      for (int i = 0; i < NUM_SLOTS; i++) order[i] = i;
      for (int i = NUM_SLOTS - 1; i > 0; i--) begin
        j        = $urandom_range(0, i);
        tmp      = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        do_write(order[i], $urandom_range(0, top_state), $urandom_range(0, top_state),
                 base + $urandom_range(0, 3));
      end

      phase_start = sent_items;
      while (sent_items - phase_start < 55) begin
        if ($urandom_range(0, 9) == 0) begin
          send_op(random_item());
        end else begin
          if ($urandom_range(0, 2) != 0) do_restart();
          len = $urandom_range(0, 8);
          for (int i = 0; i < len; i++) do_symbol(pick_symbol(base));
          do_end();
        end
      end
      phase++;
    end
  endtask

  // Result side: a random stall before each result, or the long hold-off when asked for.
  initial begin
    int stall;
    res_if.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (hold_results) begin
        hold_results = 1'b0;
        stall        = HOLD_CYCLES;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
    end
  end

  // Each accepted result is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result item moved=%0b state=%0d halted=%0b accepted=%0b",
                 $time, res_if.moved, res_if.current_state, res_if.halted, res_if.accepted);
        mismatches++;
      end else begin
        oldest = expected_verdicts.pop_front();
        if (res_if.moved !== oldest.moved) begin
          $display("%0t: moved expected %0b actual %0b", $time, oldest.moved, res_if.moved);
          mismatches++;
        end
        if (res_if.current_state !== oldest.state) begin
          $display("%0t: current_state expected %0d actual %0d",
                   $time, oldest.state, res_if.current_state);
          mismatches++;
        end
        if (res_if.halted !== oldest.halted) begin
          $display("%0t: halted expected %0b actual %0b", $time, oldest.halted, res_if.halted);
          mismatches++;
        end
        if (res_if.accepted !== oldest.accepted) begin
          $display("%0t: accepted expected %0b actual %0b",
                   $time, oldest.accepted, res_if.accepted);
          mismatches++;
        end
      end
    end
  end

  // Hang detection: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (ops_if.valid && ops_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("dfa_symbol_recognizer_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    cfg_wen            <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    ops_if.valid       <= 1'b0;
    ops_if.operation   <= OP_WRITE;
    ops_if.entry_index <= '0;
    ops_if.from_state  <= '0;
    ops_if.to_state    <= '0;
    ops_if.symbol      <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_table_fill();
    test_first_match_and_accept();
    test_large_count_and_initial();
    test_empty_table();
    test_backpressure();
    test_random_walks();

    // Let the last results drain, then give the block time to show stray items.
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("dfa_symbol_recognizer_top: match");
    end else begin
      $display("dfa_symbol_recognizer_top: mismatch");
    end
    $finish;
  end

endmodule
